// File: src/anbscan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anbscan_pkg
// Shared constants, types and helpers of the Annex-B NAL unit scanner.
// ----------------------------------------------------------------------------
package anbscan_pkg;

    // Most NAL unit records emitted per access unit
    localparam int MAX_UNITS   = 16;
    // Width of the saturating length counters
    localparam int LENGTH_BITS = 24;

    // Width of the record counter, wide enough to hold MAX_UNITS itself
    localparam int REC_W       = $clog2(MAX_UNITS + 1);
    // Fixed widths of the result fields
    localparam int TYPE_W      = 5;
    localparam int CODE_W      = 3;
    localparam int COUNT_W     = 5;

    // Header type mask and the SEI unit type
    localparam logic [7:0]        TYPE_MASK = 8'h1F;
    localparam logic [TYPE_W-1:0] SEI_TYPE  = 5'd6;

    // Shortest access unit that can be parsed at all
    localparam logic [2:0] SHORT_LIMIT = 3'd4;

    // Result kinds
    localparam logic KIND_NAL     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Summary status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_NO_CODE = 2'd2
    } t_status;

    typedef logic [LENGTH_BITS-1:0] t_len;
    typedef logic [LENGTH_BITS:0]   t_len_ext;

    // One processed item: an optional NAL record and an optional summary
    typedef struct packed {
        logic               has_rec;
        logic [TYPE_W-1:0]  rec_type;
        t_len               rec_len;
        logic [CODE_W-1:0]  rec_code;
        logic               has_sum;
        t_status            status;
        logic [CODE_W-1:0]  first_code;
        logic [COUNT_W-1:0] count;
        logic               sei;
    } t_bundle;

    // Add a small amount to a length, saturating at all ones
    function automatic t_len sat_add_len(input t_len a, input logic [2:0] b);
        t_len_ext sum;
        sum = {1'b0, a} + t_len_ext'(b);
        return sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];
    endfunction

endpackage

// File: src/anbscan_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anbscan_core
// Input register and start code scanning state; turns each byte into a
// bundle of at most one NAL record and one summary.
// ----------------------------------------------------------------------------
module anbscan_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output anbscan_pkg::t_bundle  o_bundle
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // Scanner state
    logic [1:0]                     r_zr, n_zr;
    logic [2:0]                     r_total, n_total;
    anbscan_pkg::t_len              r_len, n_len;
    logic                           r_inside, n_inside;
    logic                           r_aw, n_aw;
    logic [anbscan_pkg::TYPE_W-1:0] r_type, n_type;
    logic [anbscan_pkg::CODE_W-1:0] r_code, n_code;
    logic [anbscan_pkg::CODE_W-1:0] r_first, n_first;
    logic [anbscan_pkg::REC_W-1:0]  r_rec, n_rec;
    logic                           r_sei, n_sei;

    logic                           accept;
    logic                           proc;
    anbscan_pkg::t_len              sum_step;
    anbscan_pkg::t_len              sum_one;
    logic [anbscan_pkg::CODE_W-1:0] code_from_run;
    anbscan_pkg::t_bundle           bundle;

    assign o_stall = r_in_valid & i_queue_full;
    assign accept  = i_valid & ~o_stall;
    assign proc    = r_in_valid & ~i_queue_full;

    assign sum_step      = anbscan_pkg::sat_add_len(r_len, {1'b0, r_zr} + 3'd1);
    assign sum_one       = anbscan_pkg::sat_add_len(r_len, 3'd1);
    assign code_from_run = {1'b0, r_zr} + 3'd1;

    // Hold the accepted item until it is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    // Advance the scan state by one byte and build its results
    always_comb begin
        n_zr     = r_zr;
        n_total  = (r_total == anbscan_pkg::SHORT_LIMIT) ? r_total : r_total + 3'd1;
        n_len    = r_len;
        n_inside = r_inside;
        n_aw     = r_aw;
        n_type   = r_type;
        n_code   = r_code;
        n_first  = r_first;
        n_rec    = r_rec;
        n_sei    = r_sei;
        bundle   = '0;
        bundle.rec_code = r_code;

        if (r_aw) begin
            // header byte opens a unit
            n_aw     = 1'b0;
            n_inside = 1'b1;
            n_type   = r_byte[anbscan_pkg::TYPE_W-1:0] &
                       anbscan_pkg::TYPE_MASK[anbscan_pkg::TYPE_W-1:0];
            if (n_type == anbscan_pkg::SEI_TYPE) begin
                n_sei = 1'b1;
            end
            n_zr  = (r_byte == 8'd0) ? 2'd1 : 2'd0;
            n_len = (r_byte == 8'd0) ? '0 : anbscan_pkg::t_len'(1);
        end else if (r_inside) begin
            if (r_byte == 8'd0) begin
                // zeros beyond three belong to the open unit
                if (r_zr == 2'd3) begin
                    n_len = sum_one;
                end else begin
                    n_zr = r_zr + 2'd1;
                end
            end else if (r_byte == 8'd1 && r_zr >= 2'd2) begin
                // start code closes the open unit
                bundle.has_rec = 1'b1;
                bundle.rec_len = r_len;
                n_inside = 1'b0;
                n_zr     = 2'd0;
                n_len    = '0;
                n_rec    = r_rec + 1'b1;
                if (n_rec < anbscan_pkg::REC_W'(anbscan_pkg::MAX_UNITS)) begin
                    n_aw   = 1'b1;
                    n_code = code_from_run;
                end
            end else begin
                n_len = sum_step;
                n_zr  = 2'd0;
            end
        end else if (r_first == '0) begin
            // search for the first start code
            if (r_byte == 8'd0) begin
                if (r_zr != 2'd3) begin
                    n_zr = r_zr + 2'd1;
                end
            end else if (r_byte == 8'd1 && r_zr >= 2'd2) begin
                n_first = code_from_run;
                n_code  = code_from_run;
                n_aw    = 1'b1;
                n_zr    = 2'd0;
            end else begin
                n_zr = 2'd0;
            end
        end

        bundle.rec_type = n_type;

        if (r_last) begin
            // close the open unit, add the summary, then drop all state
            if (n_inside) begin
                bundle.has_rec = 1'b1;
                bundle.rec_len = r_aw ? anbscan_pkg::t_len'(1) : sum_step;
                n_rec = n_rec + 1'b1;
            end
            bundle.has_sum = 1'b1;
            if (n_total < anbscan_pkg::SHORT_LIMIT) begin
                bundle.status = anbscan_pkg::ST_SHORT;
            end else if (n_first == '0) begin
                bundle.status = anbscan_pkg::ST_NO_CODE;
            end else begin
                bundle.status     = anbscan_pkg::ST_OK;
                bundle.first_code = n_first;
                bundle.count      = anbscan_pkg::COUNT_W'(n_rec);
                bundle.sei        = n_sei;
            end
            n_zr     = '0;
            n_total  = '0;
            n_len    = '0;
            n_inside = 1'b0;
            n_aw     = 1'b0;
            n_type   = '0;
            n_code   = '0;
            n_first  = '0;
            n_rec    = '0;
            n_sei    = 1'b0;
        end
    end

    // Update the scan state when the held byte is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zr     <= '0;
            r_total  <= '0;
            r_len    <= '0;
            r_inside <= 1'b0;
            r_aw     <= 1'b0;
            r_type   <= '0;
            r_code   <= '0;
            r_first  <= '0;
            r_rec    <= '0;
            r_sei    <= 1'b0;
        end else if (proc) begin
            r_zr     <= n_zr;
            r_total  <= n_total;
            r_len    <= n_len;
            r_inside <= n_inside;
            r_aw     <= n_aw;
            r_type   <= n_type;
            r_code   <= n_code;
            r_first  <= n_first;
            r_rec    <= n_rec;
            r_sei    <= n_sei;
        end
    end

    assign o_push   = proc & (bundle.has_rec | bundle.has_sum);
    assign o_bundle = bundle;

endmodule

// File: src/anbscan_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anbscan_outq
// Two-entry queue of result bundles; sends the record and then the summary
// of each bundle as separate items.
// ----------------------------------------------------------------------------
module anbscan_outq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  anbscan_pkg::t_bundle              i_bundle,
    output logic                              o_full,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_record_kind,
    output logic [anbscan_pkg::TYPE_W-1:0]    o_unit_type,
    output logic [anbscan_pkg::LENGTH_BITS-1:0] o_unit_length,
    output logic [anbscan_pkg::CODE_W-1:0]    o_code_length,
    output logic [1:0]                        o_parse_status,
    output logic [anbscan_pkg::CODE_W-1:0]    o_first_code_length,
    output logic [anbscan_pkg::COUNT_W-1:0]   o_unit_count,
    output logic                              o_sei_seen,
    output logic                              o_last_result
);

    anbscan_pkg::t_bundle r_entry [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_cnt, n_cnt;
    logic                 r_phase;

    anbscan_pkg::t_bundle head;
    logic                 show_rec;
    logic                 take;
    logic                 pop;

    assign head     = r_entry[r_rd_ptr];
    assign o_full   = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign show_rec = head.has_rec & ~r_phase;
    assign take     = o_valid & ~i_stall;
    assign pop      = take & ~(show_rec & head.has_sum);

    // Store bundles
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_bundle;
        end
    end

    // Track fill level, pointers and which half of the head is shown
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
            r_phase  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_phase  <= 1'b0;
            end else if (take) begin
                r_phase  <= 1'b1;
            end
        end
    end

    // Drive the result fields from the head bundle
    always_comb begin
        o_record_kind       = anbscan_pkg::KIND_SUMMARY;
        o_unit_type         = '0;
        o_unit_length       = '0;
        o_code_length       = '0;
        o_parse_status      = head.status;
        o_first_code_length = head.first_code;
        o_unit_count        = head.count;
        o_sei_seen          = head.sei;
        o_last_result       = 1'b1;
        if (show_rec) begin
            o_record_kind       = anbscan_pkg::KIND_NAL;
            o_unit_type         = head.rec_type;
            o_unit_length       = head.rec_len;
            o_code_length       = head.rec_code;
            o_parse_status      = anbscan_pkg::ST_OK;
            o_first_code_length = '0;
            o_unit_count        = '0;
            o_sei_seen          = 1'b0;
            o_last_result       = 1'b0;
        end
    end

endmodule

// File: src/annexb_nal_unit_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_unit_scanner
// Scans Annex-B access units byte by byte and reports NAL unit records and
// a per-access-unit summary.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while o_stall is low; results leave at one
//   per cycle while i_stall is low, a last byte's record before its summary.
// Path: an accepted byte passes the input register, then the scan logic into
//   the two-entry result queue.
// Reset: synchronous, active low; clears scan state and empties the queue.
// ----------------------------------------------------------------------------
module annexb_nal_unit_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_last_byte,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_record_kind,
    output logic [anbscan_pkg::TYPE_W-1:0]      o_unit_type,
    output logic [anbscan_pkg::LENGTH_BITS-1:0] o_unit_length,
    output logic [anbscan_pkg::CODE_W-1:0]      o_code_length,
    output logic [1:0]                          o_parse_status,
    output logic [anbscan_pkg::CODE_W-1:0]      o_first_code_length,
    output logic [anbscan_pkg::COUNT_W-1:0]     o_unit_count,
    output logic                                o_sei_seen,
    output logic                                o_last_result
);

    logic                 queue_full;
    logic                 push;
    anbscan_pkg::t_bundle bundle;

    // Scan bytes
    anbscan_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_bundle     (bundle)
    );

    // Queue and serialize results
    anbscan_outq u_outq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .i_bundle            (bundle),
        .o_full              (queue_full),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_record_kind       (o_record_kind),
        .o_unit_type         (o_unit_type),
        .o_unit_length       (o_unit_length),
        .o_code_length       (o_code_length),
        .o_parse_status      (o_parse_status),
        .o_first_code_length (o_first_code_length),
        .o_unit_count        (o_unit_count),
        .o_sei_seen          (o_sei_seen),
        .o_last_result       (o_last_result)
    );

endmodule

// File: src/anbscan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anbscan_checker
// Port-level checks of the scanner's result stream.
// ----------------------------------------------------------------------------
module anbscan_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic                                o_record_kind,
    input logic [anbscan_pkg::LENGTH_BITS-1:0] o_unit_length,
    input logic [anbscan_pkg::CODE_W-1:0]      o_code_length,
    input logic [1:0]                          o_parse_status,
    input logic [anbscan_pkg::CODE_W-1:0]      o_first_code_length,
    input logic [anbscan_pkg::COUNT_W-1:0]     o_unit_count,
    input logic                                o_sei_seen,
    input logic                                o_last_result
);

    // A stalled item stays and holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_record_kind) &&
            $stable(o_unit_length) && $stable(o_unit_count))
        else $error("stalled result changed");

    // Records carry a 3- or 4-byte start code and never the final flag
    a_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind == anbscan_pkg::KIND_NAL |->
            (o_code_length == 3'd3 || o_code_length == 3'd4) && !o_last_result)
        else $error("bad record fields");

    // A failed summary reports nothing else
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind == anbscan_pkg::KIND_SUMMARY &&
            o_parse_status != anbscan_pkg::ST_OK |->
            o_first_code_length == 3'd0 && o_unit_count == '0 && !o_sei_seen)
        else $error("failed summary carries data");

    // A good summary has a real first code, a bounded count, the final flag and no length
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind == anbscan_pkg::KIND_SUMMARY &&
            o_parse_status == anbscan_pkg::ST_OK |->
            (o_first_code_length == 3'd3 || o_first_code_length == 3'd4) &&
            o_unit_count <= anbscan_pkg::COUNT_W'(anbscan_pkg::MAX_UNITS) &&
            o_last_result && o_unit_length == '0)
        else $error("bad summary fields");

endmodule

bind annexb_nal_unit_scanner anbscan_checker u_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_record_kind       (o_record_kind),
    .o_unit_length       (o_unit_length),
    .o_code_length       (o_code_length),
    .o_parse_status      (o_parse_status),
    .o_first_code_length (o_first_code_length),
    .o_unit_count        (o_unit_count),
    .o_sei_seen          (o_sei_seen),
    .o_last_result       (o_last_result)
);
